// ===== hw/rtl/booth_signed_multiplier_defines.svh =====
// ----------------------------------------------------------------------------
// Booth signed multiplier assertion macros
// Concurrent assertion wrappers used by the multiplier sequencer.
// ----------------------------------------------------------------------------
`ifndef BOOTH_SIGNED_MULTIPLIER_DEFINES_SVH
`define BOOTH_SIGNED_MULTIPLIER_DEFINES_SVH

`ifndef ASSERT_OFF

// Property that must hold at every rising edge outside reset.
`define BSM_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Condition that must never be true outside reset.
`define BSM_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) else $error(msg);

`else

`define BSM_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define BSM_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg)

`endif

`endif

// ===== hw/rtl/bsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Booth signed multiplier package
// Widths, control types and operand width conversion functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsm_pkg;

  localparam int WIDTH   = 32;
  localparam int FIELD_W = 32;
  localparam int CNT_W   = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } bsm_state_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic load;
    logic step;
    logic add;
    logic sub;
  } bsm_ctl_t;

  // Sign-extend a 32-bit field and cut it to the datapath width.
  function automatic logic [WIDTH-1:0] to_width(input logic [FIELD_W-1:0] x);
    logic [WIDTH-1:0] r;
    int               idx;
    r = '0;
    for (int k = 0; k < WIDTH; k++) begin
      idx  = (k < FIELD_W) ? k : FIELD_W - 1;
      r[k] = x[idx];
    end
    return r;
  endfunction

  // Sign-extend a datapath word and cut it to the 32-bit field.
  function automatic logic [FIELD_W-1:0] to_field(input logic [WIDTH-1:0] x);
    logic [FIELD_W-1:0] r;
    int                 idx;
    r = '0;
    for (int k = 0; k < FIELD_W; k++) begin
      idx  = (k < WIDTH) ? k : WIDTH - 1;
      r[k] = x[idx];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/booth_signed_multiplier.sv =====
// ----------------------------------------------------------------------------
// Booth signed multiplier
// Radix-2 Booth multiplier built as a row of bit cells, one product per run.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Transaction contents (lowest bits first)
//  --------+-----------+---------------------------------------------------
//  in_*    | slave     | tdata: multiplicand [31:0], multiplier [63:32]
//  out_*   | master    | tdata: product_low [31:0], product_high [63:32]
//
// A run makes one Booth add or subtract and arithmetic right shift per cycle,
// save where an untaken result holds the last step, so the multiplier bit
// count sets the number of steps. The product is registered at the edge of
// the last step, and a new transaction may be accepted on that same edge.
// The synchronous active-low reset clears the sequencer and the output flag.
// An untaken result holds the row at its last step and keeps in_tready low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module booth_signed_multiplier
  import bsm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [2*FIELD_W-1:0] in_tdata,   // multiplicand, multiplier
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [2*FIELD_W-1:0] out_tdata   // product_low, product_high
);

  bsm_ctl_t            ctl;
  logic                out_load;
  logic [WIDTH-1:0]    ld_m;
  logic [WIDTH-1:0]    ld_q;
  logic [WIDTH-1:0]    sum;
  logic [WIDTH-1:0]    q;
  logic [WIDTH:0]      carry;
  logic [WIDTH-1:0]    a_shift;
  logic [WIDTH-1:0]    q_shift;
  logic [2*FIELD_W-1:0] out_data_r, out_data_nxt;

  // Operands are sign-extended from the field and cut to the datapath width.
  assign ld_m = to_width(in_tdata[FIELD_W-1:0]);
  assign ld_q = to_width(in_tdata[2*FIELD_W-1:FIELD_W]);

  // A subtraction enters the carry chain as the two's-complement plus one.
  assign carry[0] = ctl.sub;

  // The shift runs from the top cell down: the top accumulator bit keeps
  // the sign, and the lowest sum bit moves into the top multiplier bit.
  always_comb begin
    for (int i = 0; i < WIDTH; i++) begin
      if (i == WIDTH - 1) begin
        a_shift[i] = sum[WIDTH-1];
        q_shift[i] = sum[0];
      end else begin
        a_shift[i] = sum[i+1];
        q_shift[i] = q[i+1];
      end
    end
  end

  for (genvar g = 0; g < WIDTH; g++) begin : g_cell
    bsm_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .ld_m  (ld_m[g]),
      .ld_q  (ld_q[g]),
      .a_in  (a_shift[g]),
      .q_in  (q_shift[g]),
      .cin   (carry[g]),
      .sum   (sum[g]),
      .cout  (carry[g+1]),
      .q_out (q[g])
    );
  end

  bsm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .q0         (q[0]),
    .ctl        (ctl),
    .out_load   (out_load)
  );

  // The result is taken from the shifted values of the final step, so it
  // is registered in the same edge as that step completes.
  always_comb begin
    out_data_nxt = out_data_r;
    if (out_load) begin
      out_data_nxt = {to_field(a_shift), to_field(q_shift)};
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tdata = out_data_r;

endmodule

// ===== hw/rtl/bsm_cell.sv =====
// ----------------------------------------------------------------------------
// Booth multiplier bit cell
// Holds one bit of multiplicand, accumulator and multiplier, with a full
// adder for the Booth add or subtract and the shift from its upper neighbour.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsm_cell
  import bsm_pkg::*;
(
  input  logic     clk,
  input  bsm_ctl_t ctl,
  input  logic     ld_m,
  input  logic     ld_q,
  input  logic     a_in,
  input  logic     q_in,
  input  logic     cin,
  output logic     sum,
  output logic     cout,
  output logic     q_out
);

  logic m_r, m_nxt;
  logic a_r, a_nxt;
  logic q_r, q_nxt;
  logic addend;

  // Subtraction adds the inverted multiplicand with a carry into bit zero.
  assign addend = (m_r & ctl.add) | (~m_r & ctl.sub);
  assign sum    = a_r ^ addend ^ cin;
  assign cout   = (a_r & addend) | (a_r & cin) | (addend & cin);
  assign q_out  = q_r;

  always_comb begin
    m_nxt = m_r;
    a_nxt = a_r;
    q_nxt = q_r;
    if (ctl.load) begin
      m_nxt = ld_m;
      a_nxt = 1'b0;
      q_nxt = ld_q;
    end else if (ctl.step) begin
      a_nxt = a_in;
      q_nxt = q_in;
    end
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt;
    a_r <= a_nxt;
    q_r <= q_nxt;
  end

endmodule

// ===== hw/rtl/bsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Booth multiplier sequencer
// Step counter, Booth recoding of the multiplier bit pair and the output
// register handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "booth_signed_multiplier_defines.svh"

module bsm_ctrl
  import bsm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  logic     out_tready,
  output logic     out_tvalid,
  input  logic     q0,
  output bsm_ctl_t ctl,
  output logic     out_load
);

  bsm_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             q1_r, q1_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last;
  logic             out_free;

  assign last       = (cnt_r == CNT_W'(WIDTH - 1));
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    q1_nxt    = q1_r;
    in_tready = 1'b0;
    out_load  = 1'b0;
    ctl       = '0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_RUN: begin
        if (!last) begin
          ctl.step = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end else if (out_free) begin
          ctl.step  = 1'b1;
          out_load  = 1'b1;
          in_tready = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Booth pair: 01 adds, 10 subtracts.
    ctl.add = ctl.step && !q0 && q1_r;
    ctl.sub = ctl.step && q0 && !q1_r;
    if (ctl.step) begin
      q1_nxt = q0;
    end

    if (in_tvalid && in_tready) begin
      ctl.load  = 1'b1;
      cnt_nxt   = '0;
      q1_nxt    = 1'b0;
      state_nxt = ST_RUN;
    end

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      q1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      q1_r        <= q1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `BSM_ASSERT(a_accept_starts, clk, rst_n, (in_tvalid && in_tready) |=> (state_r == ST_RUN && cnt_r == '0), "accepted transaction did not start a run")
  `BSM_ASSERT(a_load_free, clk, rst_n, out_load |-> (!out_valid_r || out_tready), "result written over an untaken result")
  `BSM_ASSERT(a_cnt_adv, clk, rst_n, (state_r == ST_RUN && !last) |=> (state_r == ST_RUN && cnt_r == $past(cnt_r) + 1'b1), "step counter did not advance")
  `BSM_ASSERT_NEVER(a_idle_step, clk, rst_n, state_r == ST_IDLE && ctl.step, "cell row stepped while idle")

endmodule
